// ----- src/assert_macros.svh -----
// Assertion macros shared by the behaviour arbiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/rba_pkg.sv -----
// Types, codes and helper functions for the robot behaviour arbiter.
package rba_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_LIGHT_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_FOLLOW_PERIOD     = 3'd1;
  localparam logic [2:0] REG_AVOID_RELEASE     = 3'd2;
  localparam logic [2:0] REG_CRUISE_SPEED      = 3'd3;
  localparam logic [2:0] REG_ESCAPE_BACK_SPEED = 3'd4;
  localparam logic [2:0] REG_ESCAPE_TURN_SPEED = 3'd5;
  localparam logic [2:0] REG_AVOID_TURN_SPEED  = 3'd6;
  localparam logic [2:0] REG_FOLLOW_BASE_SPEED = 3'd7;

  // Configuration reset values
  localparam logic [9:0]  RST_LIGHT_THRESHOLD   = 10'd100;
  localparam logic [15:0] RST_FOLLOW_PERIOD     = 16'd100;
  localparam logic [15:0] RST_AVOID_RELEASE     = 16'd1000;
  localparam logic [7:0]  RST_CRUISE_SPEED      = 8'd80;
  localparam logic [7:0]  RST_ESCAPE_BACK_SPEED = 8'd80;
  localparam logic [7:0]  RST_ESCAPE_TURN_SPEED = 8'd60;
  localparam logic [7:0]  RST_AVOID_TURN_SPEED  = 8'd60;
  localparam logic [7:0]  RST_FOLLOW_BASE_SPEED = 8'd60;

  // Drive command kinds
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_SPEED  = 2'd1;
  localparam logic [1:0] KIND_MOVE   = 2'd2;
  localparam logic [1:0] KIND_ROTATE = 2'd3;

  // Directions
  localparam logic [1:0] DIR_FWD   = 2'd0;
  localparam logic [1:0] DIR_BWD   = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  // Winning behaviour
  localparam logic [2:0] SRC_STOP   = 3'd0;
  localparam logic [2:0] SRC_CRUISE = 3'd1;
  localparam logic [2:0] SRC_FOLLOW = 3'd2;
  localparam logic [2:0] SRC_AVOID  = 3'd3;
  localparam logic [2:0] SRC_ESCAPE = 3'd4;

  typedef struct packed {
    logic [9:0]  light_threshold;
    logic [15:0] follow_period_ms;
    logic [15:0] avoid_release_ms;
    logic [7:0]  cruise_speed;
    logic [7:0]  escape_back_speed;
    logic [7:0]  escape_turn_speed;
    logic [7:0]  avoid_turn_speed;
    logic [7:0]  follow_base_speed;
  } cfg_t;

  typedef struct packed {
    logic       bump_event;
    logic       bump_left;
    logic       bump_right;
    logic       near_left;
    logic       near_right;
    logic [9:0] light_left;
    logic [9:0] light_right;
    logic       motion_done;
    logic [7:0] elapsed_ms;
  } pass_t;

  typedef struct packed {
    logic [1:0] drive_kind;
    logic [1:0] direction;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [7:0] amount;
    logic [2:0] source;
    logic [5:0] led_pattern;
    logic       led_write;
  } cmd_t;

  // Saturate a small signed sum to a wheel speed
  function automatic logic [7:0] sat8(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Bargraph for the clamped steering offset
  function automatic logic [5:0] bar_pattern(input logic signed [6:0] d);
    logic [5:0] r;
    if (d > 7'sd30) begin
      r = 6'h38;
    end else if (d > 7'sd25) begin
      r = 6'h18;
    end else if (d > 7'sd5) begin
      r = 6'h08;
    end else if (d > -7'sd5) begin
      r = 6'h09;
    end else if (d > -7'sd25) begin
      r = 6'h01;
    end else if (d > -7'sd30) begin
      r = 6'h03;
    end else begin
      r = 6'h07;
    end
    return r;
  endfunction

endpackage

// ----- src/rba_core.sv -----
// Behaviour state machines and arbitration for one controller pass.
module rba_core import rba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  pass_t item,
  input  cfg_t  cfg,
  output cmd_t  cmd
);

  localparam logic [2:0] ESC_IDLE       = 3'd0;
  localparam logic [2:0] ESC_BOTH_BACK  = 3'd1;
  localparam logic [2:0] ESC_BOTH_WAIT  = 3'd2;
  localparam logic [2:0] ESC_LEFT_BACK  = 3'd3;
  localparam logic [2:0] ESC_LEFT_WAIT  = 3'd4;
  localparam logic [2:0] ESC_RIGHT_BACK = 3'd5;
  localparam logic [2:0] ESC_RIGHT_WAIT = 3'd6;
  localparam logic [2:0] ESC_FINISH     = 3'd7;

  localparam logic [2:0] AVD_IDLE  = 3'd0;
  localparam logic [2:0] AVD_RIGHT = 3'd1;
  localparam logic [2:0] AVD_LEFT  = 3'd2;
  localparam logic [2:0] AVD_MID   = 3'd3;
  localparam logic [2:0] AVD_HOLD  = 3'd5;

  localparam logic [7:0] ARC_SLOW = 8'd20;
  localparam logic [7:0] ARC_FAST = 8'd80;
  localparam logic signed [10:0] FOLLOW_CLAMP = 11'sd40;

  // Behaviour state
  logic [2:0]  escape_phase, escape_phase_next;
  logic [7:0]  bump_tally, bump_tally_next;
  logic [7:0]  escape_speed, escape_speed_next;
  logic [1:0]  escape_direction, escape_direction_next;
  logic        escape_moving, escape_moving_next;
  logic        escape_turning, escape_turning_next;
  logic [7:0]  escape_amount, escape_amount_next;
  logic [2:0]  avoid_phase, avoid_phase_next;
  logic        last_side, last_side_next;
  logic [7:0]  obstacle_tally, obstacle_tally_next;
  logic [15:0] avoid_timer, avoid_timer_next;
  logic        avoid_running, avoid_running_next;
  logic [1:0]  avoid_direction, avoid_direction_next;
  logic [15:0] avoid_speeds, avoid_speeds_next;
  logic        follow_active, follow_active_next;
  logic [15:0] follow_timer, follow_timer_next;
  logic        follow_running, follow_running_next;
  logic [15:0] follow_speeds, follow_speeds_next;

  // Follow steering arithmetic
  logic               bright;
  logic signed [10:0] light_diff;
  logic signed [10:0] half_diff;
  logic signed [6:0]  steer;
  logic signed [9:0]  left_sum;
  logic signed [9:0]  right_sum;

  assign bright = (item.light_left >= cfg.light_threshold) ||
                  (item.light_right >= cfg.light_threshold);
  assign light_diff = signed'({1'b0, item.light_left}) - signed'({1'b0, item.light_right});
  assign half_diff  = light_diff >>> 1;

  always_comb begin
    if (half_diff > FOLLOW_CLAMP) begin
      steer = 7'(FOLLOW_CLAMP);
    end else if (half_diff < -FOLLOW_CLAMP) begin
      steer = 7'(-FOLLOW_CLAMP);
    end else begin
      steer = half_diff[6:0];
    end
  end

  assign left_sum  = signed'({2'b00, cfg.follow_base_speed}) - 10'(steer);
  assign right_sum = signed'({2'b00, cfg.follow_base_speed}) + 10'(steer);

  always_comb begin
    escape_phase_next     = escape_phase;
    bump_tally_next       = bump_tally;
    escape_speed_next     = escape_speed;
    escape_direction_next = escape_direction;
    escape_moving_next    = escape_moving;
    escape_turning_next   = escape_turning;
    escape_amount_next    = escape_amount;
    avoid_phase_next      = avoid_phase;
    last_side_next        = last_side;
    obstacle_tally_next   = obstacle_tally;
    avoid_running_next    = avoid_running;
    avoid_direction_next  = avoid_direction;
    avoid_speeds_next     = avoid_speeds;
    follow_active_next    = follow_active;
    follow_running_next   = follow_running;
    follow_speeds_next    = follow_speeds;
    cmd                   = '0;

    // Advance running timers
    avoid_timer_next  = avoid_running ? avoid_timer + 16'(item.elapsed_ms) : avoid_timer;
    follow_timer_next = follow_running ? follow_timer + 16'(item.elapsed_ms) : follow_timer;

    // Bumper handler
    if (item.bump_event) begin
      if (item.bump_left && item.bump_right) begin
        escape_phase_next = ESC_BOTH_BACK;
      end else if (item.bump_left) begin
        if (escape_phase != ESC_BOTH_WAIT) escape_phase_next = ESC_LEFT_BACK;
      end else if (item.bump_right) begin
        if (escape_phase != ESC_BOTH_WAIT) escape_phase_next = ESC_RIGHT_BACK;
      end
    end

    // Follow
    if (!follow_active) begin
      if (bright) begin
        follow_timer_next   = '0;
        follow_running_next = 1'b1;
        follow_active_next  = 1'b1;
      end
    end else if (follow_timer_next > cfg.follow_period_ms) begin
      if (bright) begin
        follow_speeds_next = {sat8(left_sum), sat8(right_sum)};
        cmd.led_pattern    = bar_pattern(steer);
        cmd.led_write      = 1'b1;
      end else begin
        follow_running_next = 1'b0;
        follow_active_next  = 1'b0;
      end
      follow_timer_next = '0;
    end

    // Avoid
    unique case (avoid_phase) inside
      AVD_IDLE: begin
        if (item.near_left && item.near_right) begin
          avoid_phase_next = AVD_MID;
        end else if (item.near_left) begin
          avoid_phase_next = AVD_LEFT;
        end else if (item.near_right) begin
          avoid_phase_next = AVD_RIGHT;
        end
      end
      AVD_MID: begin
        avoid_direction_next = last_side ? DIR_RIGHT : DIR_LEFT;
        avoid_speeds_next    = {cfg.avoid_turn_speed, cfg.avoid_turn_speed};
        if (!(item.near_left || item.near_right)) begin
          if (obstacle_tally > 8'd3) begin
            obstacle_tally_next = '0;
            avoid_timer_next    = '0;
          end else begin
            avoid_timer_next = 16'd400;
          end
          avoid_running_next = 1'b1;
          avoid_phase_next   = AVD_HOLD;
        end
      end
      AVD_RIGHT, AVD_LEFT: begin
        avoid_direction_next = DIR_FWD;
        avoid_speeds_next    = (avoid_phase == AVD_RIGHT) ? {ARC_SLOW, ARC_FAST}
                                                          : {ARC_FAST, ARC_SLOW};
        if (item.near_left && item.near_right) avoid_phase_next = AVD_MID;
        if (!((avoid_phase == AVD_RIGHT) ? item.near_right : item.near_left)) begin
          avoid_timer_next   = 16'd500;
          avoid_running_next = 1'b1;
          avoid_phase_next   = AVD_HOLD;
        end
        last_side_next      = (avoid_phase == AVD_RIGHT);
        obstacle_tally_next = obstacle_tally + 8'd1;
      end
      AVD_HOLD: begin
        if (avoid_timer_next > cfg.avoid_release_ms) begin
          avoid_running_next = 1'b0;
          avoid_timer_next   = '0;
          avoid_phase_next   = AVD_IDLE;
        end
      end
      default: begin
      end
    endcase

    // Escape
    unique case (escape_phase_next) inside
      ESC_BOTH_BACK: begin
        escape_speed_next     = cfg.escape_back_speed;
        escape_direction_next = DIR_BWD;
        escape_moving_next    = 1'b1;
        escape_amount_next    = (bump_tally > 8'd3) ? 8'd200 : 8'd140;
        escape_phase_next     = ESC_BOTH_WAIT;
        bump_tally_next       = bump_tally + 8'd2;
      end
      ESC_BOTH_WAIT: begin
        if (!escape_moving) begin
          escape_speed_next = cfg.escape_turn_speed;
          if (bump_tally > 8'd3) begin
            escape_amount_next    = 8'd110;
            escape_direction_next = DIR_RIGHT;
            bump_tally_next       = '0;
          end else begin
            escape_direction_next = DIR_LEFT;
            escape_amount_next    = 8'd75;
          end
          escape_turning_next = 1'b1;
          escape_phase_next   = ESC_FINISH;
        end
      end
      ESC_LEFT_BACK, ESC_RIGHT_BACK: begin
        escape_speed_next     = cfg.escape_back_speed;
        escape_direction_next = DIR_BWD;
        escape_moving_next    = 1'b1;
        escape_amount_next    = (bump_tally > 8'd3) ? 8'd160 : 8'd100;
        escape_phase_next     = escape_phase_next + 3'd1;
        bump_tally_next       = bump_tally + 8'd1;
      end
      ESC_LEFT_WAIT, ESC_RIGHT_WAIT: begin
        if (!escape_moving) begin
          escape_speed_next     = cfg.escape_turn_speed;
          escape_direction_next = (escape_phase_next == ESC_LEFT_WAIT) ? DIR_RIGHT : DIR_LEFT;
          escape_turning_next   = 1'b1;
          if (bump_tally > 8'd3) begin
            escape_amount_next = 8'd100;
            bump_tally_next    = '0;
          end else begin
            escape_amount_next = 8'd65;
          end
          escape_phase_next = ESC_FINISH;
        end
      end
      ESC_FINISH: begin
        if (!(escape_moving || escape_turning)) escape_phase_next = ESC_IDLE;
      end
      default: begin
      end
    endcase

    // Arbitration, highest priority first
    if (escape_phase_next != ESC_IDLE) begin
      cmd.source = SRC_ESCAPE;
      if (escape_amount_next != 8'd0) begin
        if (escape_turning_next || escape_moving_next) begin
          cmd.drive_kind = escape_turning_next ? KIND_ROTATE : KIND_MOVE;
          cmd.direction  = escape_direction_next;
          cmd.left_speed = escape_speed_next;
          cmd.amount     = escape_amount_next;
        end
        escape_amount_next = '0;
      end else if (!(escape_moving_next || escape_turning_next)) begin
        cmd.drive_kind = KIND_SPEED;
        cmd.direction  = escape_direction_next;
        cmd.left_speed = escape_speed_next;
      end else if (item.motion_done) begin
        escape_moving_next  = 1'b0;
        escape_turning_next = 1'b0;
      end
    end else if (avoid_phase_next != AVD_IDLE) begin
      cmd.source      = SRC_AVOID;
      cmd.drive_kind  = KIND_SPEED;
      cmd.direction   = avoid_direction_next;
      cmd.left_speed  = avoid_speeds_next[15:8];
      cmd.right_speed = avoid_speeds_next[7:0];
    end else if (follow_active_next) begin
      cmd.source      = SRC_FOLLOW;
      cmd.drive_kind  = KIND_SPEED;
      cmd.left_speed  = follow_speeds_next[15:8];
      cmd.right_speed = follow_speeds_next[7:0];
    end else begin
      cmd.source      = SRC_CRUISE;
      cmd.drive_kind  = KIND_SPEED;
      cmd.left_speed  = cfg.cruise_speed;
      cmd.right_speed = cfg.cruise_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase     <= ESC_IDLE;
      bump_tally       <= '0;
      escape_speed     <= '0;
      escape_direction <= DIR_FWD;
      escape_moving    <= 1'b0;
      escape_turning   <= 1'b0;
      escape_amount    <= '0;
      avoid_phase      <= AVD_IDLE;
      last_side        <= 1'b0;
      obstacle_tally   <= '0;
      avoid_timer      <= '0;
      avoid_running    <= 1'b0;
      avoid_direction  <= DIR_FWD;
      avoid_speeds     <= '0;
      follow_active    <= 1'b0;
      follow_timer     <= '0;
      follow_running   <= 1'b0;
      follow_speeds    <= '0;
    end else if (step) begin
      escape_phase     <= escape_phase_next;
      bump_tally       <= bump_tally_next;
      escape_speed     <= escape_speed_next;
      escape_direction <= escape_direction_next;
      escape_moving    <= escape_moving_next;
      escape_turning   <= escape_turning_next;
      escape_amount    <= escape_amount_next;
      avoid_phase      <= avoid_phase_next;
      last_side        <= last_side_next;
      obstacle_tally   <= obstacle_tally_next;
      avoid_timer      <= avoid_timer_next;
      avoid_running    <= avoid_running_next;
      avoid_direction  <= avoid_direction_next;
      avoid_speeds     <= avoid_speeds_next;
      follow_active    <= follow_active_next;
      follow_timer     <= follow_timer_next;
      follow_running   <= follow_running_next;
      follow_speeds    <= follow_speeds_next;
    end
  end

endmodule

// ----- src/robot_behaviour_arbiter_top.sv -----
// Top level of the robot behaviour arbiter: ports, configuration and result register.
//
// Usage: every request on the slave stream is one controller pass (bumpers,
// IR obstacle flags, two light readings, motion-done flag and elapsed
// milliseconds). For each request exactly one drive command leaves on the
// master stream, with the winning behaviour (escape, avoid, follow, cruise)
// and, after a follow update, a bargraph pattern for the six LEDs.
// Timing: the command appears on m_tvalid in the cycle after the request is
// taken. Throughput: one request per cycle unless the sink stalls; the
// behaviour state machines and the arbitration settle in one pass of logic
// in front of the result register, so that register is the only stage.
// Stall: s_tready stays high while the result register is empty or is being
// emptied in the same cycle; a held result blocks new requests, nothing is
// dropped.
// Configuration: cfg_we writes cfg_data into register cfg_index at once;
// write only while no request is in flight.
// Reset: rst (synchronous) restores the default registers, idles all
// behaviours, stops both timers and empties the result register.
module robot_behaviour_arbiter_top import rba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // bump_event[0], bump_left[1], bump_right[2], near_left[3], near_right[4],
  // light_left[14:5], light_right[24:15], motion_done[25], elapsed_ms[33:26], zero fill
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // drive_kind[1:0], direction[3:2], left_speed[11:4], right_speed[19:12],
  // amount[27:20], source[30:28], led_pattern[36:31], led_write[37], zero fill
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

  cfg_t  cfg;
  pass_t item;
  cmd_t  cmd;
  cmd_t  result;
  logic  take;

  // Unpack the request
  assign item.bump_event  = s_tdata[0];
  assign item.bump_left   = s_tdata[1];
  assign item.bump_right  = s_tdata[2];
  assign item.near_left   = s_tdata[3];
  assign item.near_right  = s_tdata[4];
  assign item.light_left  = s_tdata[14:5];
  assign item.light_right = s_tdata[24:15];
  assign item.motion_done = s_tdata[25];
  assign item.elapsed_ms  = s_tdata[33:26];

  // Accept while the result register is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_threshold   <= RST_LIGHT_THRESHOLD;
      cfg.follow_period_ms  <= RST_FOLLOW_PERIOD;
      cfg.avoid_release_ms  <= RST_AVOID_RELEASE;
      cfg.cruise_speed      <= RST_CRUISE_SPEED;
      cfg.escape_back_speed <= RST_ESCAPE_BACK_SPEED;
      cfg.escape_turn_speed <= RST_ESCAPE_TURN_SPEED;
      cfg.avoid_turn_speed  <= RST_AVOID_TURN_SPEED;
      cfg.follow_base_speed <= RST_FOLLOW_BASE_SPEED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_THRESHOLD:   cfg.light_threshold   <= cfg_data[9:0];
        REG_FOLLOW_PERIOD:     cfg.follow_period_ms  <= cfg_data;
        REG_AVOID_RELEASE:     cfg.avoid_release_ms  <= cfg_data;
        REG_CRUISE_SPEED:      cfg.cruise_speed      <= cfg_data[7:0];
        REG_ESCAPE_BACK_SPEED: cfg.escape_back_speed <= cfg_data[7:0];
        REG_ESCAPE_TURN_SPEED: cfg.escape_turn_speed <= cfg_data[7:0];
        REG_AVOID_TURN_SPEED:  cfg.avoid_turn_speed  <= cfg_data[7:0];
        REG_FOLLOW_BASE_SPEED: cfg.follow_base_speed <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Behaviour machines and arbitration; state advances on each taken request
  rba_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (take),
    .item (item),
    .cfg  (cfg),
    .cmd  (cmd)
  );

  // Result register: load on a taken request, drop valid once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= cmd;
    end
  end

  assign m_tdata = {2'b00, result.led_write, result.led_pattern, result.source,
                    result.amount, result.right_speed, result.left_speed,
                    result.direction, result.drive_kind};

  // Every taken request leaves a command in the result register
  `RBA_ASSERT(a_take_loads, take |=> m_tvalid, "request taken but no result held")
  // Cruise is always a fallback, so the stop source never wins
  `RBA_ASSERT(a_no_stop, m_tvalid |-> (result.source != SRC_STOP), "stop source produced")
  // Only escape can withhold a drive command
  `RBA_ASSERT(a_none_escape,
    (m_tvalid && (result.drive_kind == KIND_NONE)) |-> (result.source == SRC_ESCAPE),
    "empty command from a behaviour other than escape")
  // A bargraph write always lights at least one LED
  `RBA_ASSERT(a_led_lit, (m_tvalid && result.led_write) |-> (result.led_pattern != 6'd0),
    "bargraph write with all LEDs dark")

endmodule

// ----- tb/robot_behaviour_arbiter_top_tb.sv -----
// Self-checking testbench for the robot behaviour arbiter: directed passes, then random phases.
module robot_behaviour_arbiter_top_tb;
  import rba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Fixed moves and speeds of the behaviours
  localparam int ARC_SLOW         = 20;
  localparam int ARC_FAST         = 80;
  localparam int STEER_LIMIT      = 40;
  localparam int TALLY_LIMIT      = 3;
  localparam int BACK_BOTH_SHORT  = 140;
  localparam int BACK_BOTH_LONG   = 200;
  localparam int BACK_SIDE_SHORT  = 100;
  localparam int BACK_SIDE_LONG   = 160;
  localparam int TURN_BOTH_SHORT  = 75;
  localparam int TURN_BOTH_LONG   = 110;
  localparam int TURN_SIDE_SHORT  = 65;
  localparam int TURN_SIDE_LONG   = 100;
  localparam int HOLD_AFTER_ARC   = 500;
  localparam int HOLD_AFTER_PIVOT = 400;

  localparam int ITEMS_PER_PHASE = 285;
  localparam int QUIET_LIMIT     = 1000;

  typedef enum logic [2:0] {
    ESC_IDLE       = 3'd0,
    ESC_BOTH       = 3'd1,
    ESC_BOTH_WAIT  = 3'd2,
    ESC_LEFT       = 3'd3,
    ESC_LEFT_WAIT  = 3'd4,
    ESC_RIGHT      = 3'd5,
    ESC_RIGHT_WAIT = 3'd6,
    ESC_SETTLE     = 3'd7
  } escape_phase_t;

  typedef enum logic [2:0] {
    AV_IDLE      = 3'd0,
    AV_ARC_RIGHT = 3'd1,
    AV_ARC_LEFT  = 3'd2,
    AV_PIVOT     = 3'd3,
    AV_HOLD      = 3'd5
  } avoid_phase_t;

  typedef struct {
    pass_t p;
    bit    typed;
    cmd_t  want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  // A directed row may carry its own expected command alongside the request
  logic row_typed;
  cmd_t row_cmd;

  int   send_idle_pct;
  int   recv_stall_pct;
  int   mismatches;
  cmd_t pending_cmds[$];
  row_t directed_rows[$];
  cfg_t phase_cfg;
  bit   obst_left, obst_right;

  // Predictor state
  cfg_t          model_cfg;
  escape_phase_t esc_phase;
  logic [7:0]    bump_tally, esc_speed, esc_amount;
  logic [1:0]    esc_dir;
  logic          esc_moving, esc_turning;
  avoid_phase_t  av_phase;
  logic          last_right;
  logic [7:0]    obstacle_tally, av_left_spd, av_right_spd;
  logic [15:0]   av_timer;
  logic          av_timer_on;
  logic [1:0]    av_dir;
  logic          follow_on, follow_timer_on;
  logic [15:0]   follow_timer;
  logic [7:0]    follow_left_spd, follow_right_spd;

  robot_behaviour_arbiter_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clip a steering sum to a wheel speed
  function automatic logic [7:0] clip_speed(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  function automatic cmd_t mk_cmd(input logic [1:0] kind, input logic [1:0] dir,
                                  input int lsp, input int rsp, input int amt,
                                  input logic [2:0] src, input logic [5:0] leds,
                                  input logic lw);
    cmd_t c;
    c.drive_kind  = kind;
    c.direction   = dir;
    c.left_speed  = lsp[7:0];
    c.right_speed = rsp[7:0];
    c.amount      = amt[7:0];
    c.source      = src;
    c.led_pattern = leds;
    c.led_write   = lw;
    return c;
  endfunction

  task automatic add_row(input bit bev, input bit bl, input bit br, input bit nl,
                         input bit nr, input int ll, input int lr, input bit done,
                         input int el, input bit typed = 1'b0, input cmd_t want = '0);
    row_t r;
    r.p.bump_event  = bev;
    r.p.bump_left   = bl;
    r.p.bump_right  = br;
    r.p.near_left   = nl;
    r.p.near_right  = nr;
    r.p.light_left  = ll[9:0];
    r.p.light_right = lr[9:0];
    r.p.motion_done = done;
    r.p.elapsed_ms  = el[7:0];
    r.typed         = typed;
    r.want          = want;
    directed_rows.push_back(r);
  endtask

  task automatic reset_model();
    model_cfg.light_threshold   = RST_LIGHT_THRESHOLD;
    model_cfg.follow_period_ms  = RST_FOLLOW_PERIOD;
    model_cfg.avoid_release_ms  = RST_AVOID_RELEASE;
    model_cfg.cruise_speed      = RST_CRUISE_SPEED;
    model_cfg.escape_back_speed = RST_ESCAPE_BACK_SPEED;
    model_cfg.escape_turn_speed = RST_ESCAPE_TURN_SPEED;
    model_cfg.avoid_turn_speed  = RST_AVOID_TURN_SPEED;
    model_cfg.follow_base_speed = RST_FOLLOW_BASE_SPEED;
    esc_phase        = ESC_IDLE;
    bump_tally       = '0;
    esc_speed        = '0;
    esc_amount       = '0;
    esc_dir          = DIR_FWD;
    esc_moving       = 1'b0;
    esc_turning      = 1'b0;
    av_phase         = AV_IDLE;
    last_right       = 1'b0;
    obstacle_tally   = '0;
    av_timer         = '0;
    av_timer_on      = 1'b0;
    av_dir           = DIR_FWD;
    av_left_spd      = '0;
    av_right_spd     = '0;
    follow_on        = 1'b0;
    follow_timer_on  = 1'b0;
    follow_timer     = '0;
    follow_left_spd  = '0;
    follow_right_spd = '0;
  endtask

  task automatic write_model_reg(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      REG_LIGHT_THRESHOLD:   model_cfg.light_threshold   = val[9:0];
      REG_FOLLOW_PERIOD:     model_cfg.follow_period_ms  = val;
      REG_AVOID_RELEASE:     model_cfg.avoid_release_ms  = val;
      REG_CRUISE_SPEED:      model_cfg.cruise_speed      = val[7:0];
      REG_ESCAPE_BACK_SPEED: model_cfg.escape_back_speed = val[7:0];
      REG_ESCAPE_TURN_SPEED: model_cfg.escape_turn_speed = val[7:0];
      REG_AVOID_TURN_SPEED:  model_cfg.avoid_turn_speed  = val[7:0];
      REG_FOLLOW_BASE_SPEED: model_cfg.follow_base_speed = val[7:0];
      default: ;
    endcase
  endtask

  // One controller pass: timers, bumpers, follow, avoid, escape, then pick the winner
  task automatic predict_command(input pass_t p, output cmd_t c);
    logic bright, toward_right;
    int   d, dif;
    c = '0;

    // advance the running timers first
    if (av_timer_on) begin
      av_timer = av_timer + 16'(p.elapsed_ms);
    end
    if (follow_timer_on) begin
      follow_timer = follow_timer + 16'(p.elapsed_ms);
    end

    if (p.bump_event) begin
      if (p.bump_left && p.bump_right) begin
        esc_phase = ESC_BOTH;
      end else if (p.bump_left) begin
        if (esc_phase != ESC_BOTH_WAIT) esc_phase = ESC_LEFT;
      end else if (p.bump_right) begin
        if (esc_phase != ESC_BOTH_WAIT) esc_phase = ESC_RIGHT;
      end
    end

    // follow the brighter sensor
    bright = (p.light_left >= model_cfg.light_threshold) ||
             (p.light_right >= model_cfg.light_threshold);
    if (!follow_on) begin
      if (bright) begin
        follow_timer    = '0;
        follow_timer_on = 1'b1;
        follow_on       = 1'b1;
      end
    end else if (follow_timer > model_cfg.follow_period_ms) begin
      if (bright) begin
        d   = int'(p.light_left) - int'(p.light_right);
        dif = (d >= 0) ? d / 2 : -((1 - d) / 2);
        if (dif > STEER_LIMIT) dif = STEER_LIMIT;
        if (dif < -STEER_LIMIT) dif = -STEER_LIMIT;
        follow_left_spd  = clip_speed(int'(model_cfg.follow_base_speed) - dif);
        follow_right_spd = clip_speed(int'(model_cfg.follow_base_speed) + dif);
        if (dif > 30) c.led_pattern = 6'h38;
        else if (dif > 25) c.led_pattern = 6'h18;
        else if (dif > 5) c.led_pattern = 6'h08;
        else if (dif > -5) c.led_pattern = 6'h09;
        else if (dif > -25) c.led_pattern = 6'h01;
        else if (dif > -30) c.led_pattern = 6'h03;
        else c.led_pattern = 6'h07;
        c.led_write = 1'b1;
      end else begin
        follow_timer_on = 1'b0;
        follow_on       = 1'b0;
      end
      follow_timer = '0;
    end

    // steer around IR obstacles
    case (av_phase)
      AV_IDLE: begin
        if (p.near_left && p.near_right) av_phase = AV_PIVOT;
        else if (p.near_left) av_phase = AV_ARC_LEFT;
        else if (p.near_right) av_phase = AV_ARC_RIGHT;
      end
      AV_PIVOT: begin
        av_dir       = last_right ? DIR_RIGHT : DIR_LEFT;
        av_left_spd  = model_cfg.avoid_turn_speed;
        av_right_spd = model_cfg.avoid_turn_speed;
        if (!(p.near_left || p.near_right)) begin
          if (int'(obstacle_tally) > TALLY_LIMIT) begin
            obstacle_tally = '0;
            av_timer       = '0;
          end else begin
            av_timer = 16'(HOLD_AFTER_PIVOT);
          end
          av_timer_on = 1'b1;
          av_phase    = AV_HOLD;
        end
      end
      AV_ARC_RIGHT, AV_ARC_LEFT: begin
        toward_right = (av_phase == AV_ARC_RIGHT);
        av_dir       = DIR_FWD;
        av_left_spd  = toward_right ? 8'(ARC_SLOW) : 8'(ARC_FAST);
        av_right_spd = toward_right ? 8'(ARC_FAST) : 8'(ARC_SLOW);
        if (p.near_left && p.near_right) av_phase = AV_PIVOT;
        if (!(toward_right ? p.near_right : p.near_left)) begin
          av_timer    = 16'(HOLD_AFTER_ARC);
          av_timer_on = 1'b1;
          av_phase    = AV_HOLD;
        end
        last_right     = toward_right;
        obstacle_tally = obstacle_tally + 8'd1;
      end
      AV_HOLD: begin
        if (av_timer > model_cfg.avoid_release_ms) begin
          av_timer_on = 1'b0;
          av_timer    = '0;
          av_phase    = AV_IDLE;
        end
      end
      default: ;
    endcase

    // back off a bumper hit, then turn away
    case (esc_phase)
      ESC_BOTH: begin
        esc_speed  = model_cfg.escape_back_speed;
        esc_dir    = DIR_BWD;
        esc_moving = 1'b1;
        esc_amount = (int'(bump_tally) > TALLY_LIMIT) ? 8'(BACK_BOTH_LONG)
                                                      : 8'(BACK_BOTH_SHORT);
        esc_phase  = ESC_BOTH_WAIT;
        bump_tally = bump_tally + 8'd2;
      end
      ESC_BOTH_WAIT: begin
        if (!esc_moving) begin
          esc_speed = model_cfg.escape_turn_speed;
          if (int'(bump_tally) > TALLY_LIMIT) begin
            esc_amount = 8'(TURN_BOTH_LONG);
            esc_dir    = DIR_RIGHT;
            bump_tally = '0;
          end else begin
            esc_dir    = DIR_LEFT;
            esc_amount = 8'(TURN_BOTH_SHORT);
          end
          esc_turning = 1'b1;
          esc_phase   = ESC_SETTLE;
        end
      end
      ESC_LEFT, ESC_RIGHT: begin
        esc_speed  = model_cfg.escape_back_speed;
        esc_dir    = DIR_BWD;
        esc_moving = 1'b1;
        esc_amount = (int'(bump_tally) > TALLY_LIMIT) ? 8'(BACK_SIDE_LONG)
                                                      : 8'(BACK_SIDE_SHORT);
        esc_phase  = (esc_phase == ESC_LEFT) ? ESC_LEFT_WAIT : ESC_RIGHT_WAIT;
        bump_tally = bump_tally + 8'd1;
      end
      ESC_LEFT_WAIT, ESC_RIGHT_WAIT: begin
        if (!esc_moving) begin
          esc_speed   = model_cfg.escape_turn_speed;
          esc_dir     = (esc_phase == ESC_LEFT_WAIT) ? DIR_RIGHT : DIR_LEFT;
          esc_turning = 1'b1;
          if (int'(bump_tally) > TALLY_LIMIT) begin
            esc_amount = 8'(TURN_SIDE_LONG);
            bump_tally = '0;
          end else begin
            esc_amount = 8'(TURN_SIDE_SHORT);
          end
          esc_phase = ESC_SETTLE;
        end
      end
      ESC_SETTLE: begin
        if (!(esc_moving || esc_turning)) esc_phase = ESC_IDLE;
      end
      default: ;
    endcase

    // highest active behaviour wins: escape, avoid, follow, cruise
    if (esc_phase != ESC_IDLE) begin
      c.source = SRC_ESCAPE;
      if (esc_amount != 8'd0) begin
        if (esc_turning) begin
          c.drive_kind = KIND_ROTATE;
          c.direction  = esc_dir;
          c.left_speed = esc_speed;
          c.amount     = esc_amount;
        end else if (esc_moving) begin
          c.drive_kind = KIND_MOVE;
          c.direction  = esc_dir;
          c.left_speed = esc_speed;
          c.amount     = esc_amount;
        end
        esc_amount = '0;
      end else if (!(esc_moving || esc_turning)) begin
        c.drive_kind = KIND_SPEED;
        c.direction  = esc_dir;
        c.left_speed = esc_speed;
      end else if (p.motion_done) begin
        esc_moving  = 1'b0;
        esc_turning = 1'b0;
      end
    end else if (av_phase != AV_IDLE) begin
      c.source      = SRC_AVOID;
      c.drive_kind  = KIND_SPEED;
      c.direction   = av_dir;
      c.left_speed  = av_left_spd;
      c.right_speed = av_right_spd;
    end else if (follow_on) begin
      c.source      = SRC_FOLLOW;
      c.drive_kind  = KIND_SPEED;
      c.left_speed  = follow_left_spd;
      c.right_speed = follow_right_spd;
    end else begin
      c.source      = SRC_CRUISE;
      c.drive_kind  = KIND_SPEED;
      c.left_speed  = model_cfg.cruise_speed;
      c.right_speed = model_cfg.cruise_speed;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted request, compare every accepted command
  always @(posedge clk) begin : monitor
    pass_t seen;
    cmd_t  want, got;
    if (rst) begin
      reset_model();
      pending_cmds.delete();
    end else begin
      if (cfg_we) begin
        write_model_reg(cfg_index, cfg_data);
      end
      if (s_tvalid && s_tready) begin
        seen.bump_event  = s_tdata[0];
        seen.bump_left   = s_tdata[1];
        seen.bump_right  = s_tdata[2];
        seen.near_left   = s_tdata[3];
        seen.near_right  = s_tdata[4];
        seen.light_left  = s_tdata[14:5];
        seen.light_right = s_tdata[24:15];
        seen.motion_done = s_tdata[25];
        seen.elapsed_ms  = s_tdata[33:26];
        predict_command(seen, want);
        // a typed row overrides the prediction, the predictor state still advances
        if (row_typed) begin
          want = row_cmd;
        end
        pending_cmds.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.drive_kind  = m_tdata[1:0];
        got.direction   = m_tdata[3:2];
        got.left_speed  = m_tdata[11:4];
        got.right_speed = m_tdata[19:12];
        got.amount      = m_tdata[27:20];
        got.source      = m_tdata[30:28];
        got.led_pattern = m_tdata[36:31];
        got.led_write   = m_tdata[37];
        if (pending_cmds.size() == 0) begin
          $display("%0t: drive command %h with none pending", $time, m_tdata);
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          check_field("drive_kind", 8'(want.drive_kind), 8'(got.drive_kind));
          check_field("direction", 8'(want.direction), 8'(got.direction));
          check_field("left_speed", want.left_speed, got.left_speed);
          check_field("right_speed", want.right_speed, got.right_speed);
          check_field("amount", want.amount, got.amount);
          check_field("source", 8'(want.source), 8'(got.source));
          check_field("led_pattern", 8'(want.led_pattern), 8'(got.led_pattern));
          check_field("led_write", 8'(want.led_write), 8'(got.led_write));
        end
      end
    end
  end

  // Receiver: stall at random at the current rate
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hold a request until taken; drop valid for a random gap first
  task automatic send_pass(input pass_t p, input logic typed, input cmd_t want);
    logic [39:0] word;
    word        = '0;
    word[0]     = p.bump_event;
    word[1]     = p.bump_left;
    word[2]     = p.bump_right;
    word[3]     = p.near_left;
    word[4]     = p.near_right;
    word[14:5]  = p.light_left;
    word[24:15] = p.light_right;
    word[25]    = p.motion_done;
    word[33:26] = p.elapsed_ms;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= word;
    row_typed <= typed;
    row_cmd   <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t k);
    write_reg(REG_LIGHT_THRESHOLD, {6'd0, k.light_threshold});
    write_reg(REG_FOLLOW_PERIOD, k.follow_period_ms);
    write_reg(REG_AVOID_RELEASE, k.avoid_release_ms);
    write_reg(REG_CRUISE_SPEED, {8'd0, k.cruise_speed});
    write_reg(REG_ESCAPE_BACK_SPEED, {8'd0, k.escape_back_speed});
    write_reg(REG_ESCAPE_TURN_SPEED, {8'd0, k.escape_turn_speed});
    write_reg(REG_AVOID_TURN_SPEED, {8'd0, k.avoid_turn_speed});
    write_reg(REG_FOLLOW_BASE_SPEED, {8'd0, k.follow_base_speed});
    cfg_we <= 1'b0;
  endtask

  // Let every outstanding command drain, then hold a little longer than the latency
  task automatic wait_drained();
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Random pass: obstacles come in runs, some light readings cluster around the threshold
  task automatic next_random_pass(output pass_t p);
    int mode, edge_val, other;
    if ($urandom_range(0, 99) < 12) obst_left = ~obst_left;
    if ($urandom_range(0, 99) < 12) obst_right = ~obst_right;
    p.near_left   = obst_left;
    p.near_right  = obst_right;
    p.bump_event  = ($urandom_range(0, 99) < 10);
    p.bump_left   = 1'($urandom_range(0, 1));
    p.bump_right  = 1'($urandom_range(0, 1));
    p.motion_done = ($urandom_range(0, 99) < 35);
    p.elapsed_ms  = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 40))
                                                  : 8'($urandom_range(0, 255));
    mode = $urandom_range(0, 9);
    if (mode < 3) begin
      p.light_left  = 10'($urandom_range(0, 127));
      p.light_right = 10'($urandom_range(0, 127));
    end else if (mode < 5) begin
      edge_val = int'(phase_cfg.light_threshold) + $urandom_range(0, 6) - 3;
      if (edge_val < 0) edge_val = 0;
      if (edge_val > 1023) edge_val = 1023;
      other = $urandom_range(0, 1023);
      if ($urandom_range(0, 1)) begin
        p.light_left  = edge_val[9:0];
        p.light_right = other[9:0];
      end else begin
        p.light_left  = other[9:0];
        p.light_right = edge_val[9:0];
      end
    end else if (mode < 9) begin
      p.light_left  = 10'($urandom_range(0, 1023));
      p.light_right = 10'($urandom_range(0, 1023));
    end else begin
      p.light_left  = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
      p.light_right = ~p.light_left;
    end
  endtask

  initial begin : stimulus
    pass_t p;
    cfg_t  k;

    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_LIGHT_THRESHOLD;
    cfg_data       = '0;
    row_typed      = 1'b0;
    row_cmd        = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    obst_left      = 1'b0;
    obst_right     = 1'b0;
    phase_cfg      = '0;
    phase_cfg.light_threshold = RST_LIGHT_THRESHOLD;

    // Directed passes under the reset settings.
    //      bev bl br nl nr  left right done  ms
    // idle after reset: plain cruise
    add_row(0, 0, 0, 0, 0,    0,    0, 0,   0, 1,
            mk_cmd(KIND_SPEED, DIR_FWD, 80, 80, 0, SRC_CRUISE, 6'h00, 1'b0));
    // bright light starts follow, speeds still zero
    add_row(0, 0, 0, 0, 0, 1023,    0, 0,   0, 1,
            mk_cmd(KIND_SPEED, DIR_FWD, 0, 0, 0, SRC_FOLLOW, 6'h00, 1'b0));
    // period passed: steer hard left-bright, clamp and full bargraph
    add_row(0, 0, 0, 0, 0, 1023,    0, 0, 255, 1,
            mk_cmd(KIND_SPEED, DIR_FWD, 20, 100, 0, SRC_FOLLOW, 6'h38, 1'b1));
    add_row(0, 0, 0, 0, 0,    0, 1023, 0, 255);
    // reading exactly at the threshold, centre of the bargraph
    add_row(0, 0, 0, 0, 0,  100,   99, 0, 101);
    // light gone: follow drops out
    add_row(0, 0, 0, 0, 0,   99,   98, 0, 200);
    // left obstacle arc, then both sides: pivot, then hold and release
    add_row(0, 0, 0, 1, 0,    0,    0, 0,   0);
    add_row(0, 0, 0, 1, 0,    0,    0, 0,  10);
    add_row(0, 0, 0, 1, 1,    0,    0, 0,  10);
    add_row(0, 0, 0, 1, 1,    0,    0, 0,  10);
    add_row(0, 0, 0, 0, 0,    0,    0, 0,  10);
    add_row(0, 0, 0, 0, 0,    0,    0, 0, 255);
    add_row(0, 0, 0, 0, 0,    0,    0, 0, 255);
    add_row(0, 0, 0, 0, 0,    0,    0, 0, 255);
    // right obstacle arc cleared at once
    add_row(0, 0, 0, 0, 1,    0,    0, 0,   0);
    add_row(0, 0, 0, 0, 0,    0,    0, 0,   0);
    // both bumpers: back off, wait, turn, wait, settle
    add_row(1, 1, 1, 0, 0,    0,    0, 0,   0, 1,
            mk_cmd(KIND_MOVE, DIR_BWD, 80, 0, 140, SRC_ESCAPE, 6'h00, 1'b0));
    add_row(0, 0, 0, 0, 0,    0,    0, 0,   0, 1,
            mk_cmd(KIND_NONE, DIR_FWD, 0, 0, 0, SRC_ESCAPE, 6'h00, 1'b0));
    add_row(0, 0, 0, 0, 0,    0,    0, 1,   0);
    add_row(0, 0, 0, 0, 0,    0,    0, 0,   0);
    add_row(0, 0, 0, 0, 0,    0,    0, 1,   0);
    add_row(0, 0, 0, 0, 0,    0,    0, 0,   0);
    // left bumper, then right bumper while the move flag is still set
    add_row(1, 1, 0, 0, 0,    0,    0, 0,   0);
    add_row(1, 0, 1, 0, 0,    0,    0, 1,   0);
    // bumper change with neither pressed
    add_row(1, 0, 0, 0, 0,    0,    0, 0,   0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_pass(directed_rows[i].p, directed_rows[i].typed, directed_rows[i].want);
    end
    s_tvalid  <= 1'b0;
    row_typed <= 1'b0;
    wait_drained();

    // Random phases, each under its own settings and idling rates
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          k.light_threshold   = RST_LIGHT_THRESHOLD;
          k.follow_period_ms  = RST_FOLLOW_PERIOD;
          k.avoid_release_ms  = RST_AVOID_RELEASE;
          k.cruise_speed      = RST_CRUISE_SPEED;
          k.escape_back_speed = RST_ESCAPE_BACK_SPEED;
          k.escape_turn_speed = RST_ESCAPE_TURN_SPEED;
          k.avoid_turn_speed  = RST_AVOID_TURN_SPEED;
          k.follow_base_speed = RST_FOLLOW_BASE_SPEED;
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          // low extremes: always bright, timers expire at once, base below range
          k              = '0;
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
        2: begin
          // high extremes: follow rarely starts, avoid hold never ends here
          k.light_threshold   = 10'd1023;
          k.follow_period_ms  = 16'hFFFF;
          k.avoid_release_ms  = 16'hFFFF;
          k.cruise_speed      = 8'd255;
          k.escape_back_speed = 8'd255;
          k.escape_turn_speed = 8'd255;
          k.avoid_turn_speed  = 8'd255;
          k.follow_base_speed = 8'd255;
          send_idle_pct  = 0;
          recv_stall_pct = 61;
        end
        default: begin
          k.light_threshold   = 10'($urandom_range(20, 700));
          k.follow_period_ms  = 16'($urandom_range(0, 400));
          k.avoid_release_ms  = 16'($urandom_range(0, 2000));
          k.cruise_speed      = 8'($urandom_range(0, 255));
          k.escape_back_speed = 8'($urandom_range(0, 255));
          k.escape_turn_speed = 8'($urandom_range(0, 255));
          k.avoid_turn_speed  = 8'($urandom_range(0, 255));
          k.follow_base_speed = 8'($urandom_range(40, 215));
          send_idle_pct  = (ph == 3) ? 13 : 0;
          recv_stall_pct = (ph == 3) ? 13 : 0;
        end
      endcase
      load_settings(k);
      phase_cfg = k;
      repeat (ITEMS_PER_PHASE) begin
        next_random_pass(p);
        send_pass(p, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
      wait_drained();
    end

    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("PASS robot_behaviour_arbiter_top");
    end else begin
      $display("FAIL robot_behaviour_arbiter_top");
    end
    $finish;
  end

  // End the run if neither stream moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no request or command moved for %0d cycles", $time, QUIET_LIMIT);
    $display("FAIL robot_behaviour_arbiter_top");
    $finish;
  end

endmodule

// ----- robot_behaviour_arbiter_top.f -----
+incdir+src
src/rba_pkg.sv
src/rba_core.sv
src/robot_behaviour_arbiter_top.sv
tb/robot_behaviour_arbiter_top_tb.sv
